FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the knob decoder RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define RKD_ASSERT_ALWAYS(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("assertion failed");

// when pre holds, post must hold in the next cycle
`define RKD_ASSERT_NEXT(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: rtl/rkd_pkg.sv
// ---------------------------------------------------------------------------
// rkd_pkg
// Types and constants shared by the rotary knob decoder modules.
// ---------------------------------------------------------------------------
package rkd_pkg;

  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Q1.15 full scale
  localparam logic [LEVEL_W-1:0] Q_ONE = 16'h8000;

  // threshold register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 2'd1;

  localparam logic [LEVEL_W-1:0] HIGH_THR_RST = 16'd31130;
  localparam logic [LEVEL_W-1:0] LOW_THR_RST  = 16'd1638;

  // rotation event codes
  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_CW   = 2'd1;
  localparam logic [1:0] ROT_CCW  = 2'd2;

  // switch event codes
  localparam logic [1:0] SW_NONE    = 2'd0;
  localparam logic [1:0] SW_PRESS   = 2'd1;
  localparam logic [1:0] SW_RELEASE = 2'd2;

  // bit i set when transition code i is a legal Gray step
  localparam logic [15:0] VALID_STEP = 16'h6996;

  localparam logic [7:0] HIST_CW  = 8'h2b;
  localparam logic [7:0] HIST_CCW = 8'h17;

  typedef struct packed {
    logic [LEVEL_W-1:0] high;
    logic [LEVEL_W-1:0] low;
  } thr_t;

endpackage

FILE: rtl/rkd_quad.sv
// ---------------------------------------------------------------------------
// rkd_quad
// Quadrature transition tracker: code and history registers, detent detect.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rkd_quad
  import rkd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       clk_level_i,
  input  logic       dt_level_i,
  output logic [1:0] rotation_event_o
);

  logic [3:0] code_q, code_d;
  logic [7:0] hist_q, hist_d;
  logic       legal;

  always_comb begin
    code_d = {code_q[1:0], dt_level_i, clk_level_i};
    legal  = VALID_STEP[code_d];
    hist_d = legal ? {hist_q[3:0], code_d} : hist_q;
    if (legal && hist_d == HIST_CW) begin
      rotation_event_o = ROT_CW;
    end else if (legal && hist_d == HIST_CCW) begin
      rotation_event_o = ROT_CCW;
    end else begin
      rotation_event_o = ROT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
      hist_q <= '0;
    end else if (step_i) begin
      code_q <= code_d;
      hist_q <= hist_d;
    end
  end

  `RKD_ASSERT_NEXT(a_cw_hist, clk_i, rst_ni,
                   step_i && rotation_event_o == ROT_CW, hist_q == HIST_CW)

endmodule

FILE: rtl/rkd_debounce.sv
// ---------------------------------------------------------------------------
// rkd_debounce
// Switch IIR low-pass filter with hysteresis and press/release detect.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rkd_debounce
  import rkd_pkg::*;
#(
  parameter int unsigned FILTER_WEIGHT = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       switch_level_i,
  input  thr_t       thr_i,
  output logic [1:0] switch_event_o
);

  localparam int unsigned DIV    = 3 + FILTER_WEIGHT;
  localparam int unsigned NUM_W  = $clog2(DIV * (2 ** LEVEL_W));
  localparam int unsigned DIV_LG = $clog2(DIV);
  localparam int unsigned SHIFT  = NUM_W + DIV_LG;
  localparam int unsigned PROD_W = 2 * NUM_W + 1;
  // reciprocal exact for every NUM_W-bit numerator
  localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + DIV - 1) / DIV;
  localparam logic [NUM_W:0] RECIP = RECIP_L[NUM_W:0];

  logic [LEVEL_W-1:0] level_q, level_d, filt;
  logic               stable_q, stable_d;
  logic [NUM_W-1:0]   num;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    num  = (switch_level_i ? NUM_W'(3 * 32768) : NUM_W'(0))
         + NUM_W'(level_q) * NUM_W'(FILTER_WEIGHT);
    prod = PROD_W'(num) * PROD_W'(RECIP);
    filt = LEVEL_W'(prod >> SHIFT);

    level_d        = filt;
    stable_d       = stable_q;
    switch_event_o = SW_NONE;
    if (!stable_q && filt >= thr_i.high) begin
      level_d        = Q_ONE;
      stable_d       = 1'b1;
      switch_event_o = SW_PRESS;
    end else if (stable_q && filt <= thr_i.low) begin
      level_d        = '0;
      stable_d       = 1'b0;
      switch_event_o = SW_RELEASE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= Q_ONE;
      stable_q <= 1'b1;
    end else if (step_i) begin
      level_q  <= level_d;
      stable_q <= stable_d;
    end
  end

  `RKD_ASSERT_ALWAYS(a_level_max, clk_i, rst_ni, level_q <= Q_ONE)
  `RKD_ASSERT_NEXT(a_press_stable, clk_i, rst_ni,
                   step_i && switch_event_o == SW_PRESS, stable_q && level_q == Q_ONE)

endmodule

FILE: rtl/rotary_knob_decoder_debouncer.sv
// ---------------------------------------------------------------------------
// rotary_knob_decoder_debouncer
// Quadrature knob decoder with IIR switch debounce, one result per sample.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o): one beat per pin sample tick,
//    carrying the encoder clock, data and push switch levels.
//  - Output channel (out_valid_o/out_ready_i): exactly one beat per input
//    beat, with rotation_event_o (none/cw/ccw) and switch_event_o
//    (none/press/release).
//  - Config channel (cfg_valid_i/cfg_ready_o): index 0 high threshold,
//    index 1 low threshold, both Q1.15; other indexes are dropped. Always
//    ready; write only while no sample is in flight.
//  - Timing: an input beat passes the input register, then the result
//    register. Throughput: one sample per cycle while out_ready_i is high;
//    the filter multiply-by-reciprocal and the history compare sit in one stage.
//  - Reset: code and history clear, filter level 1.0, switch stable high,
//    thresholds back to 31130/1638, both registers empty.
//  - Stall: when out_ready_i is low with a result pending, the result register
//    holds; the input register takes a beat only while it is empty, then
//    in_ready_o stays low until the result is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rotary_knob_decoder_debouncer
  import rkd_pkg::*;
#(
  parameter int unsigned FILTER_WEIGHT = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // sample beats
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 clk_level_i,
  input  logic                 dt_level_i,
  input  logic                 switch_level_i,
  // result beats
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           rotation_event_o,
  output logic [1:0]           switch_event_o,
  // register writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LEVEL_W-1:0]   cfg_data_i
);

  // input register
  logic       in_valid_q;
  logic       clk_lvl_q, dt_lvl_q, sw_lvl_q;
  // result register
  logic       out_valid_q;
  logic [1:0] rot_q, sw_ev_q;
  logic [1:0] rot_d, sw_ev_d;
  // thresholds
  thr_t       thr_q;

  logic advance;  // result register can take a new value
  logic step;     // input register item is processed this cycle

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      clk_lvl_q <= clk_level_i;
      dt_lvl_q  <= dt_level_i;
      sw_lvl_q  <= switch_level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.high <= HIGH_THR_RST;
      thr_q.low  <= LOW_THR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_HIGH_THR: thr_q.high <= cfg_data_i;
        CFG_LOW_THR:  thr_q.low  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rkd_quad u_quad (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .clk_level_i      (clk_lvl_q),
    .dt_level_i       (dt_lvl_q),
    .rotation_event_o (rot_d)
  );

  rkd_debounce #(
    .FILTER_WEIGHT (FILTER_WEIGHT)
  ) u_debounce (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .switch_level_i (sw_lvl_q),
    .thr_i          (thr_q),
    .switch_event_o (sw_ev_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      rot_q   <= rot_d;
      sw_ev_q <= sw_ev_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign rotation_event_o = rot_q;
  assign switch_event_o   = sw_ev_q;

  // a held sample is not lost while the result side is stalled
  `RKD_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_q && !advance, in_valid_q)

endmodule
